### rtl/clg_pkg.sv
// Shared types, constants and byte classification for the Coleman-Liau grade block.
package clg_pkg;

  localparam int K_LETTER = 588;
  localparam int K_SENT   = 2960;
  localparam int K_WORD   = 1580;
  localparam int K_DEN    = 100;

  localparam int STEP_BITS = 6;
  localparam logic [STEP_BITS-1:0] STEP_LAST_DONE = 6'd31;

  localparam int GRADE_BITS = 5;
  localparam int TOTAL_BITS = 16;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_MUL,
    ST_SUB,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    CL_NONE,
    CL_LETTER,
    CL_SPACE,
    CL_END
  } char_class_t;

  typedef struct packed {
    logic cnt_en;
    logic mul_en;
    logic sub_en;
    logic step_en;
    logic load_out;
  } clg_cmd_t;

  typedef struct packed {
    logic step_last;
  } clg_sts_t;

  function automatic char_class_t char_class(input logic [7:0] c);
    char_class_t r;
    r = CL_NONE;
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      r = CL_LETTER;
    end else if ((c >= 8'h09 && c <= 8'h0D) || c == 8'h20) begin
      r = CL_SPACE;
    end else if (c == 8'h2E || c == 8'h3F || c == 8'h21) begin
      r = CL_END;
    end
    return r;
  endfunction

  // Multiples of the denominator that mark a grade boundary: 2 (grade 1) and
  // odd 3..31 (half-up boundaries of grades 2..16).
  function automatic logic is_tap(input logic [STEP_BITS-1:0] m);
    return (m == 6'd2) || (m[0] && m >= 6'd3 && m <= 6'd31);
  endfunction

endpackage

### rtl/clg_ctrl.sv
// Controller state machine: byte intake, grade sequencing and output slot.
module clg_ctrl import clg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_tlast,
  output logic     in_tready,
  input  logic     out_tready,
  output logic     out_tvalid,
  input  clg_sts_t sts,
  output clg_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        in_tready  = 1'b1;
        cmd.cnt_en = in_tvalid;
        if (in_tvalid && in_tlast) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub_en = 1'b1;
        state_nxt  = ST_STEP;
      end
      ST_STEP: begin
        cmd.step_en = 1'b1;
        if (sts.step_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

### rtl/clg_dp.sv
// Datapath: saturating tallies, numerator/denominator products, grade stepper, output word.
module clg_dp import clg_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            char_code,
  input  clg_cmd_t              cmd,
  output clg_sts_t              sts,
  output logic [GRADE_BITS-1:0] grade_code,
  output logic [TOTAL_BITS-1:0] letter_total,
  output logic [TOTAL_BITS-1:0] word_total,
  output logic [TOTAL_BITS-1:0] sentence_total
);

  localparam int NW = COUNT_BITS + 15;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [COUNT_BITS-1:0] letter_r, space_r, sent_r;
  logic [COUNT_BITS-1:0] letter_nxt, space_nxt, sent_nxt;
  logic [COUNT_BITS-1:0] words;
  char_class_t           cls;

  logic signed [NW-1:0]  ml_r, ms_r, mw_r, den_r, n2_r, acc_r;
  logic signed [NW-1:0]  acc_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;
  logic [GRADE_BITS-1:0] grade_r;

  assign cls   = char_class(char_code);
  assign words = (space_r == CNT_MAX) ? CNT_MAX : space_r + 1'b1;

  always_comb begin
    letter_nxt = letter_r;
    space_nxt  = space_r;
    sent_nxt   = sent_r;
    if (cmd.load_out) begin
      letter_nxt = '0;
      space_nxt  = '0;
      sent_nxt   = '0;
    end else if (cmd.cnt_en) begin
      unique case (cls)
        CL_LETTER: if (letter_r != CNT_MAX) letter_nxt = letter_r + 1'b1;
        CL_SPACE:  if (space_r != CNT_MAX)  space_nxt  = space_r + 1'b1;
        CL_END:    if (sent_r != CNT_MAX)   sent_nxt   = sent_r + 1'b1;
        CL_NONE:   ;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      letter_r <= '0;
      space_r  <= '0;
      sent_r   <= '0;
    end else begin
      letter_r <= letter_nxt;
      space_r  <= space_nxt;
      sent_r   <= sent_nxt;
    end
  end

  assign step_nxt = step_r + 1'b1;
  assign acc_nxt  = acc_r + den_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      ml_r  <= $signed(NW'(letter_r) * NW'(K_LETTER));
      ms_r  <= $signed(NW'(sent_r) * NW'(K_SENT));
      mw_r  <= $signed(NW'(words) * NW'(K_WORD));
      den_r <= $signed(NW'(words) * NW'(K_DEN));
    end
    if (cmd.sub_en) begin
      n2_r    <= (ml_r - ms_r - mw_r) <<< 1;
      acc_r   <= '0;
      step_r  <= '0;
      grade_r <= '0;
    end else if (cmd.step_en) begin
      acc_r  <= acc_nxt;
      step_r <= step_nxt;
      if (is_tap(step_nxt) && (n2_r >= acc_nxt)) begin
        grade_r <= grade_r + 1'b1;
      end
    end
    if (cmd.load_out) begin
      grade_code     <= grade_r;
      letter_total   <= TOTAL_BITS'(letter_r);
      word_total     <= TOTAL_BITS'(words);
      sentence_total <= TOTAL_BITS'(sent_r);
    end
  end

  assign sts.step_last = (step_r == STEP_LAST_DONE);

endmodule

### rtl/coleman_liau_grade.sv
// Top level of the Coleman-Liau readability grade block.
//
//   channel | direction | tdata                              | tlast
//   in_     | slave     | [7:0] char_code                    | is_final
//   out_    | master    | grade, letters, words, sentences   | -
//
// Non-final bytes are taken one per cycle while intake is open (ST_RUN). A final
// byte closes intake and starts the grade sequence: a product state, a subtract
// state, then one comparator stepping through multiples of the denominator,
// then a done state that loads the output word and reopens intake.
// Reset clears the tallies, the state machine and the output valid flag.
// A waiting result does not block intake of the next text; only the load for a
// second final byte waits in the done state until the output register is free.
module coleman_liau_grade import clg_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [4:0] grade_code, [20:5] letter_total,
                                  // [36:21] word_total, [52:37] sentence_total, [55:53] zero
);

  clg_cmd_t              cmd;
  clg_sts_t              sts;
  logic [GRADE_BITS-1:0] grade_code;
  logic [TOTAL_BITS-1:0] letter_total, word_total, sentence_total;

  clg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  clg_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .char_code      (in_tdata),
    .cmd            (cmd),
    .sts            (sts),
    .grade_code     (grade_code),
    .letter_total   (letter_total),
    .word_total     (word_total),
    .sentence_total (sentence_total)
  );

  assign out_tdata = {3'b000, sentence_total, word_total, letter_total, grade_code};

`ifndef SYNTHESIS
  a_final_stops_intake: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("intake not stopped after final byte");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid)
    else $error("output word not presented after load");

  a_grade_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:0] <= 5'd16)
    else $error("grade code out of range");
`endif

endmodule
